// File: hw/rtl/fixed_length_frame_receiver_defines.svh
// assertion macros shared by the frame receiver modules
// expects clk and rst in the scope where a macro is used
`ifndef FIXED_LENGTH_FRAME_RECEIVER_DEFINES_SVH
`define FIXED_LENGTH_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, off while in reset
`define FLFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define FLFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/flfr_pkg.sv
// shared types and constants for the fixed-length frame receiver
// no dependencies
`timescale 1ns / 1ps

package flfr_pkg;

  // payload buffer sizing
  localparam int PAYLOAD_MAX_DEFAULT = 16;
  localparam int PAYLOAD_MAX_HIGH    = 64;
  localparam int CMD_CNT_W           = $clog2(PAYLOAD_MAX_HIGH + 1);

  // field widths
  localparam int BYTE_W     = 8;
  localparam int BYTE_IDX_W = 4;
  localparam int LEN_W      = 5;
  localparam int TICK_W     = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 2'd1;

  // register reset values
  localparam logic [LEN_W-1:0]  LENGTH_RESET  = 5'd10;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd5000;

  // framing bytes
  localparam logic [BYTE_W-1:0] START_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] END_BYTE   = 8'hFD;

  // item kinds
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // frame command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef struct packed {
    logic              func;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]     payload_byte;
    logic [BYTE_IDX_W-1:0] byte_index;
    logic                  last_byte;
  } out_item_t;

  // one completed frame handed from front to back
  typedef struct packed {
    logic                 bank;
    logic [CMD_CNT_W-1:0] count;
  } frame_cmd_t;

endpackage

// File: hw/rtl/flfr_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module flfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/flfr_front.sv
// front end: config registers, item intake, frame state and payload writes
// depends on flfr_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "fixed_length_frame_receiver_defines.svh"

module flfr_front #(
  parameter int PAYLOAD_MAX = flfr_pkg::PAYLOAD_MAX_DEFAULT,
  localparam int IDX_W  = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1,
  localparam int ADDR_W = IDX_W + 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [flfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [flfr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  flfr_pkg::in_item_t             in_item,
  output logic                           ram_we,
  output logic [ADDR_W-1:0]              ram_waddr,
  output logic [flfr_pkg::BYTE_W-1:0]    ram_wdata,
  output logic                           cmd_push,
  output flfr_pkg::frame_cmd_t           cmd,
  input  logic                           frame_done
);

  import flfr_pkg::*;

  localparam int CNT_W = $clog2(PAYLOAD_MAX + 1);
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_READ     = 2'd1;
  localparam logic [1:0] PH_WAIT_END = 2'd2;

  localparam logic [1:0] BUSY_FULL = 2'd2;

  logic [LEN_W-1:0]  payload_length;
  logic [TICK_W-1:0] timeout_ticks;

  logic [1:0]        phase, phase_next;
  logic [CNT_W-1:0]  stored_count, stored_count_next;
  logic [TICK_W-1:0] elapsed, elapsed_next;
  logic              bank, bank_next;
  logic [1:0]        busy, busy_next;

  logic [CMP_W-1:0]  len_ext;
  logic [CNT_W-1:0]  eff_len;
  logic [CNT_W-1:0]  count_after;
  logic [TICK_W-1:0] elapsed_inc;
  logic              accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_length <= LENGTH_RESET;
      timeout_ticks  <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAYLOAD_LENGTH: payload_length <= cfg_data[LEN_W-1:0];
        REG_TIMEOUT_TICKS:  timeout_ticks  <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp frame length to 1 .. PAYLOAD_MAX
  always_comb begin
    len_ext = CMP_W'(payload_length);
    if (len_ext == '0) begin
      eff_len = CNT_W'(1);
    end else if (len_ext > CMP_W'(PAYLOAD_MAX)) begin
      eff_len = CNT_W'(PAYLOAD_MAX);
    end else begin
      eff_len = CNT_W'(len_ext);
    end
  end

  // stall only while the back end owns both buffer banks
  assign in_ready = (busy != BUSY_FULL);
  assign accept   = in_valid && in_ready;

  assign ram_waddr = {bank, IDX_W'(stored_count)};
  assign ram_wdata = in_item.rx_byte;
  assign cmd.bank  = bank;
  assign cmd.count = CMD_CNT_W'(stored_count);

  assign elapsed_inc = (elapsed != '1) ? elapsed + TICK_W'(1) : elapsed;
  assign count_after = (stored_count < eff_len) ? stored_count + CNT_W'(1) : stored_count;

  // frame state update per accepted item
  always_comb begin
    phase_next        = phase;
    stored_count_next = stored_count;
    elapsed_next      = elapsed;
    bank_next         = bank;
    ram_we            = 1'b0;
    cmd_push          = 1'b0;
    if (accept) begin
      if (in_item.func == FUNC_TICK) begin
        if (phase == PH_READ || phase == PH_WAIT_END) begin
          if (elapsed_inc >= timeout_ticks) begin
            // timeout drops the partial frame
            phase_next        = PH_IDLE;
            stored_count_next = '0;
            elapsed_next      = '0;
          end else begin
            elapsed_next = elapsed_inc;
          end
        end
      end else begin
        case (phase)
          PH_READ: begin
            ram_we            = (stored_count < eff_len);
            stored_count_next = count_after;
            if (count_after >= eff_len) begin
              phase_next = PH_WAIT_END;
            end
          end
          PH_WAIT_END: begin
            if (in_item.rx_byte == END_BYTE) begin
              cmd_push          = (stored_count != '0);
              bank_next         = (stored_count != '0) ? ~bank : bank;
              phase_next        = PH_IDLE;
              stored_count_next = '0;
              elapsed_next      = '0;
            end
          end
          default: begin
            if (in_item.rx_byte == START_BYTE) begin
              phase_next        = PH_READ;
              stored_count_next = '0;
              elapsed_next      = '0;
            end else begin
              phase_next = PH_IDLE;
            end
          end
        endcase
      end
    end
  end

  // banks held by the back end
  always_comb begin
    case ({cmd_push, frame_done})
      2'b10:   busy_next = busy + 2'd1;
      2'b01:   busy_next = busy - 2'd1;
      default: busy_next = busy;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      stored_count <= '0;
      elapsed      <= '0;
      bank         <= 1'b0;
      busy         <= '0;
    end else begin
      phase        <= phase_next;
      stored_count <= stored_count_next;
      elapsed      <= elapsed_next;
      bank         <= bank_next;
      busy         <= busy_next;
    end
  end

  `FLFR_ASSERT_NOW(a_busy_bound, 1'b1, busy <= BUSY_FULL, "more frames in flight than banks")
  `FLFR_ASSERT_NOW(a_idle_clean, phase == PH_IDLE, (stored_count == '0) && (elapsed == '0), "idle with frame state left")
  `FLFR_ASSERT_NEXT(a_start_opens, accept && (in_item.func == FUNC_BYTE) && (phase == PH_IDLE) && (in_item.rx_byte == START_BYTE), (phase == PH_READ) && (stored_count == '0), "start byte did not open a frame")

endmodule

// File: hw/rtl/flfr_queue.sv
// two-entry queue of completed frame commands between front and back
// depends on flfr_pkg
`timescale 1ns / 1ps

module flfr_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  flfr_pkg::frame_cmd_t push_cmd,
  input  logic                 pop,
  output logic                 not_empty,
  output flfr_pkg::frame_cmd_t head
);

  import flfr_pkg::*;

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  frame_cmd_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [FILL_W-1:0] fill;

  assign not_empty = (fill != '0);
  assign head      = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + FILL_W'(1);
        2'b01:   fill <= fill - FILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: hw/rtl/flfr_back.sv
// back end: reads a finished frame from the buffer and sends its bytes
// depends on flfr_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "fixed_length_frame_receiver_defines.svh"

module flfr_back #(
  parameter int PAYLOAD_MAX = flfr_pkg::PAYLOAD_MAX_DEFAULT,
  localparam int IDX_W  = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1,
  localparam int ADDR_W = IDX_W + 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  input  flfr_pkg::frame_cmd_t        cmd,
  output logic                        cmd_pop,
  output logic                        ram_re,
  output logic [ADDR_W-1:0]           ram_raddr,
  input  logic [flfr_pkg::BYTE_W-1:0] ram_rdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output flfr_pkg::out_item_t         out_item,
  output logic                        frame_done
);

  import flfr_pkg::*;

  localparam int CNT_W = $clog2(PAYLOAD_MAX + 1);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_READ    = 2'd1;
  localparam logic [1:0] S_CAPTURE = 2'd2;
  localparam logic [1:0] S_SHOW    = 2'd3;

  logic [1:0]       state;
  logic             cur_bank;
  logic [CNT_W-1:0] cur_count;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_inc;

  assign idx_inc    = idx + CNT_W'(1);
  assign cmd_pop    = (state == S_IDLE) && cmd_valid;
  assign ram_re     = (state == S_READ);
  assign ram_raddr  = {cur_bank, IDX_W'(idx)};
  assign out_valid  = (state == S_SHOW);
  assign frame_done = (state == S_SHOW) && out_ready && out_item.last_byte;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= S_READ;
          end
        end
        S_READ:    state <= S_CAPTURE;
        S_CAPTURE: state <= S_SHOW;
        S_SHOW: begin
          if (out_ready) begin
            state <= out_item.last_byte ? S_IDLE : S_READ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // frame position and output register
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cur_bank  <= cmd.bank;
          cur_count <= CNT_W'(cmd.count);
          idx       <= '0;
        end
      end
      S_CAPTURE: begin
        out_item.payload_byte <= ram_rdata;
        out_item.byte_index   <= BYTE_IDX_W'(idx);
        out_item.last_byte    <= (idx_inc == cur_count);
      end
      S_SHOW: begin
        if (out_ready && !out_item.last_byte) begin
          idx <= idx_inc;
        end
      end
      default: ;
    endcase
  end

  `FLFR_ASSERT_NOW(a_pos_in_frame, state != S_IDLE, (cur_count != '0) && (idx < cur_count), "byte position outside frame")
  `FLFR_ASSERT_NOW(a_last_marks_end, out_valid && out_item.last_byte, idx_inc == cur_count, "last mark on wrong byte")
  `FLFR_ASSERT_NEXT(a_next_byte_read, (state == S_SHOW) && out_ready && !out_item.last_byte, state == S_READ, "frame not continued after byte")

endmodule

// File: hw/rtl/fixed_length_frame_receiver.sv
// top level of the fixed-length frame receiver
// depends on flfr_pkg, flfr_front, flfr_queue, flfr_back and flfr_ram
`timescale 1ns / 1ps

// Receives a stream of byte and tick items. A frame is a start byte 0xFF,
// payload_length data bytes, then the end byte 0xFD; on the end byte the
// stored bytes come out one item each with their position and a last mark.
// A frame not closed within timeout_ticks ticks of its start byte is dropped.
// The input side takes one item per clock; it holds in_ready low only while
// two completed frames are not yet fully sent, since the payload buffer has
// two banks. Sending goes through the buffer's registered read port: each
// output byte passes through the address, read and output register steps,
// then waits on out_ready before the next byte of the frame is read.
// Configuration may be written only while no frame is being sent.
module fixed_length_frame_receiver #(
  parameter int PAYLOAD_MAX = flfr_pkg::PAYLOAD_MAX_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [flfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [flfr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  flfr_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output flfr_pkg::out_item_t             out_item
);

  import flfr_pkg::*;

  localparam int IDX_W     = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
  localparam int ADDR_W    = IDX_W + 1;
  localparam int RAM_DEPTH = 2 ** ADDR_W;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              cmd_push;
  frame_cmd_t        push_cmd;
  logic              cmd_pop;
  logic              cmd_valid;
  frame_cmd_t        head_cmd;
  logic              frame_done;

  // intake and frame tracking
  flfr_front #(
    .PAYLOAD_MAX(PAYLOAD_MAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .cmd_push  (cmd_push),
    .cmd       (push_cmd),
    .frame_done(frame_done)
  );

  // two-bank payload buffer
  flfr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // completed frames waiting to be sent
  flfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (push_cmd),
    .pop      (cmd_pop),
    .not_empty(cmd_valid),
    .head     (head_cmd)
  );

  // byte sender
  flfr_back #(
    .PAYLOAD_MAX(PAYLOAD_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (head_cmd),
    .cmd_pop   (cmd_pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .frame_done(frame_done)
  );

endmodule
